// ===== design/pse_pkg.sv =====
// Package: shared types, codes and sizes for the postfix stack evaluator.
package pse_pkg;

    localparam int DEF_STACK_DEPTH = 64;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_APPLY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DIV0  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] operand;
        logic [1:0]         op_code;
    } t_in;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [2:0]         status;
        logic [6:0]         depth;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_cmd;

endpackage

// ===== design/pse_alu.sv =====
// Module: Q16.16 arithmetic unit (add, sub, mul, div), saturating; mul and div are bit-serial.
module pse_alu (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pse_pkg::t_alu_cmd     i_cmd,
    input  logic signed [31:0]    i_left,
    input  logic signed [31:0]    i_right,
    output logic                  o_done,
    output logic signed [31:0]    o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg;
    // acc: product high half / partial remainder; sh: multiplier / quotient bits
    logic [48:0] r_acc, n_acc;
    logic [47:0] r_sh, n_sh;
    logic [31:0] r_b;
    logic signed [31:0] r_res, n_res;

    logic [31:0] abs_l, abs_r;
    logic [32:0] sum33;
    logic [48:0] trial;
    logic [63:0] mag;
    logic [64:0] sval;

    assign abs_l = i_left[31]  ? 32'(-i_left)  : 32'(i_left);
    assign abs_r = i_right[31] ? 32'(-i_right) : 32'(i_right);
    assign trial = {r_acc[47:0], r_sh[47]} - {17'd0, r_b};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_sh    = r_sh;
        n_res   = r_res;
        sum33   = '0;
        mag     = '0;
        sval    = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_cnt = '0;
                    n_acc = '0;
                    if (i_cmd.op == pse_pkg::OP_ADD || i_cmd.op == pse_pkg::OP_SUB) begin
                        sum33 = (i_cmd.op == pse_pkg::OP_ADD)
                              ? {i_left[31], i_left} + {i_right[31], i_right}
                              : {i_left[31], i_left} - {i_right[31], i_right};
                        if (sum33[32] != sum33[31])
                            n_res = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        else
                            n_res = sum33[31:0];
                        n_state = S_FIN;
                    end else if (i_cmd.op == pse_pkg::OP_MUL) begin
                        n_sh = {16'd0, abs_r};
                        n_state = S_MUL;
                    end else begin
                        n_sh = {abs_l, 16'd0};
                        n_state = S_DIV;
                    end
                end
            end
            S_MUL: begin
                // shift-add, one multiplier bit per cycle, LSB first
                n_acc = {1'b0, r_acc[47:0]} + (r_sh[0] ? {17'd0, r_b} : 49'd0);
                n_sh  = {n_acc[0], r_sh[47:1]};
                n_acc = {1'b0, n_acc[48:1]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) n_state = S_FIN;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!trial[48]) begin
                    n_acc = trial;
                    n_sh  = {r_sh[46:0], 1'b1};
                end else begin
                    n_acc = {r_acc[47:0], r_sh[47]};
                    n_sh  = {r_sh[46:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) n_state = S_FIN;
            end
            default: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
        endcase
        // finish mul/div when leaving iteration
        if (r_state == S_MUL && n_state == S_FIN) begin
            mag = {n_acc[31:0], n_sh[47:16]};
            if (r_neg) begin
                // floor: -(ceil(m/65536))
                sval = -{1'b0, ({16'd0, mag[63:16]} + {47'd0, (mag[15:0] != 16'd0)})};
            end else begin
                sval = {17'd0, mag[63:16]};
            end
            if (!sval[64] && sval[63:31] != 33'd0) n_res = 32'sh7FFF_FFFF;
            else if (sval[64] && sval[63:31] != {33{1'b1}}) n_res = 32'sh8000_0000;
            else n_res = sval[31:0];
        end
        if (r_state == S_DIV && n_state == S_FIN) begin
            sval = r_neg ? -{17'd0, n_sh} : {17'd0, n_sh};
            if (!sval[64] && sval[63:31] != 33'd0) n_res = 32'sh7FFF_FFFF;
            else if (sval[64] && sval[63:31] != {33{1'b1}}) n_res = 32'sh8000_0000;
            else n_res = sval[31:0];
        end
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_res <= n_res;
        if (r_state == S_IDLE && i_cmd.start) begin
            r_neg <= i_left[31] ^ i_right[31];
            r_b   <= (i_cmd.op == pse_pkg::OP_MUL) ? abs_l : abs_r;
        end
    end

endmodule

// ===== design/postfix_stack_evaluator.sv =====
// Top level: postfix expression evaluator on a Q16.16 operand stack.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   request | in        | i_valid / o_stall    | req_type, operand, op_code
//   result  | out       | o_valid / i_stall    | top_value, status, depth
//
// Add and sub are not iterated; multiply takes 32 shift-add steps and divide
// 48 restoring-division steps. The stack memory has one read port with
// registered data, so an operator reads its right operand and then its left,
// and the new top is read after the result is written. One request is in work
// at a time. Reset clears the count and state only; stack entries are written
// before read. A held result does not block the next request; that request
// waits at the output until the held result is taken.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  pse_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output pse_pkg::t_out o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;  // read right operand
    localparam logic [2:0] S_RD2  = 3'd2;  // read left operand
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_TOP  = 3'd4;  // read new top
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;  // new top read in flight

    logic [31:0]   r_mem [STACK_DEPTH];
    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    pse_pkg::t_in  r_req;
    logic [31:0]   r_rdata, r_right;
    logic [AW-1:0] r_raddr;
    logic [2:0]    r_status;
    logic          r_ovalid;
    pse_pkg::t_out r_out;
    logic          r_busy;
    logic          r_start;

    logic alu_done;
    logic signed [31:0] alu_res;
    pse_pkg::t_alu_cmd alu_cmd;

    assign alu_cmd.start = r_start;
    assign alu_cmd.op    = r_req.op_code;

    pse_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (alu_cmd),
        .i_left   (r_rdata),
        .i_right  (r_right),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    assign o_stall = r_busy;
    assign o_valid = r_ovalid;
    assign o_res   = r_out;

    // Registered memory read.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req    <= i_req;
                        r_busy   <= 1'b1;
                        case (i_req.req_type)
                            pse_pkg::REQ_PUSH: begin
                                r_state <= S_TOP;
                                if (r_cnt == CW'(STACK_DEPTH)) begin
                                    r_status <= pse_pkg::ST_OVER;
                                end else begin
                                    r_status <= pse_pkg::ST_OK;
                                    r_mem[r_cnt[AW-1:0]] <= i_req.operand;
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                            pse_pkg::REQ_APPLY: begin
                                if (r_cnt < CW'(2)) begin
                                    r_cnt    <= '0;
                                    r_status <= pse_pkg::ST_UNDER;
                                    r_state  <= S_TOP;
                                end else begin
                                    r_status <= pse_pkg::ST_OK;
                                    r_raddr  <= AW'(r_cnt - 1'b1);
                                    r_state  <= S_RD1;
                                end
                            end
                            pse_pkg::REQ_READ: begin
                                r_status <= (r_cnt == '0) ? pse_pkg::ST_EMPTY
                                                          : pse_pkg::ST_OK;
                                r_state  <= S_TOP;
                            end
                            default: begin
                                r_cnt    <= '0;
                                r_status <= pse_pkg::ST_OK;
                                r_state  <= S_TOP;
                            end
                        endcase
                    end
                    // unless an operator starts, park the read address at entry zero
                    if (!(i_valid && !o_stall && i_req.req_type == pse_pkg::REQ_APPLY
                          && r_cnt >= CW'(2)))
                        r_raddr <= '0;
                end
                S_RD1: begin
                    r_raddr <= AW'(r_cnt - CW'(2));
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_right <= r_rdata;   // right operand arrived
                    if (r_req.op_code == pse_pkg::OP_DIV && r_rdata == '0) begin
                        r_cnt    <= '0;
                        r_status <= pse_pkg::ST_DIV0;
                        r_state  <= S_TOP;
                    end else begin
                        r_cnt   <= r_cnt - CW'(2);
                        r_start <= 1'b1;
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    // r_rdata now holds left operand steady through the start cycle
                    r_start <= 1'b0;
                    if (alu_done) begin
                        r_mem[r_cnt[AW-1:0]] <= alu_res;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_TOP;
                    end
                end
                S_TOP: begin
                    r_raddr <= AW'(r_cnt - 1'b1);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_OUT;
                end
                default: begin
                    // memory data for the top arrives this cycle; hold until the
                    // previous result is taken
                    if (!r_ovalid) begin
                        r_out.top_value <= (r_cnt == '0) ? 32'sd0 : r_rdata;
                        r_out.status    <= r_status;
                        r_out.depth     <= 7'(r_cnt);
                        r_ovalid <= 1'b1;
                        r_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/pse_checker.sv =====
// Checker: port-level properties of the postfix stack evaluator, with bind.
module pse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input pse_pkg::t_out o_res
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    // Error codes that clear the stack, and a read of an empty stack, report an empty stack.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.status == pse_pkg::ST_DIV0 || o_res.status == pse_pkg::ST_UNDER
                    || o_res.status == pse_pkg::ST_EMPTY)
        |-> o_res.depth == 7'd0 && o_res.top_value == 32'sd0)
        else $error("error status with nonempty stack");

    // An accepted request holds off the next one.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while another is in work");

    // An empty stack shows zero on top.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.depth == 7'd0 |-> o_res.top_value == 32'sd0)
        else $error("empty stack with nonzero top");

    // Reset drops any result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

// ===== sim/tb_postfix_stack_evaluator.sv =====
// Testbench for the postfix stack evaluator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

class stack_scoreboard;
    logic signed [31:0] stack_mem [64];
    int                 count;
    pse_pkg::t_out      expected_q [$];
    int                 errors;

    function new();
        count = 0;
        errors = 0;
    endfunction

    function logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Compute the result of one accepted request and queue it.
    function void note_request(pse_pkg::t_in r);
        longint        lhs, rhs, prod;
        logic [2:0]    st;
        pse_pkg::t_out res;
        st = pse_pkg::ST_OK;
        case (r.req_type)
            pse_pkg::REQ_PUSH: begin
                if (count < 64) begin
                    stack_mem[count] = r.operand;
                    count++;
                end else begin
                    st = pse_pkg::ST_OVER;
                end
            end
            pse_pkg::REQ_APPLY: begin
                if (count < 2) begin
                    count = 0;
                    st = pse_pkg::ST_UNDER;
                end else begin
                    rhs = stack_mem[count-1];
                    lhs = stack_mem[count-2];
                    count -= 2;
                    if (r.op_code == pse_pkg::OP_DIV && rhs == 0) begin
                        count = 0;
                        st = pse_pkg::ST_DIV0;
                    end else begin
                        case (r.op_code)
                            pse_pkg::OP_ADD: stack_mem[count] = sat32(lhs + rhs);
                            pse_pkg::OP_SUB: stack_mem[count] = sat32(lhs - rhs);
                            pse_pkg::OP_MUL: begin
                                prod = lhs * rhs;
                                stack_mem[count] = sat32(prod >>> 16);
                            end
                            default: stack_mem[count] = sat32((lhs * 65536) / rhs);
                        endcase
                        count++;
                    end
                end
            end
            pse_pkg::REQ_READ: if (count == 0) st = pse_pkg::ST_EMPTY;
            default: count = 0;
        endcase
        res.top_value = (count == 0) ? 32'sd0 : stack_mem[count-1];
        res.status = st;
        res.depth = count[6:0];
        expected_q.push_back(res);
    endfunction

    function void check_result(pse_pkg::t_out got);
        pse_pkg::t_out exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.top_value !== exp_res.top_value) begin
            $display("%0t: top_value expected %h actual %h", $time,
                     exp_res.top_value, got.top_value);
            errors++;
        end
        if (got.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, got.status);
            errors++;
        end
        if (got.depth !== exp_res.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time,
                     exp_res.depth, got.depth);
            errors++;
        end
    endfunction
endclass

module tb_postfix_stack_evaluator;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic o_stall, o_valid;
    pse_pkg::t_in  i_req = '0;
    pse_pkg::t_out o_res;

    stack_scoreboard sb = new();
    bit   recv_on = 0;
    int   stall_left = 0;

    postfix_stack_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one request, hold it until accepted, then note it.
    task automatic send_request(pse_pkg::t_in r);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_req <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic push_val(logic signed [31:0] v);
        pse_pkg::t_in r;
        r = '0;
        r.req_type = pse_pkg::REQ_PUSH;
        r.operand = v;
        r.op_code = 2'($urandom);
        send_request(r);
    endtask

    task automatic apply_op(logic [1:0] op);
        pse_pkg::t_in r;
        r.req_type = pse_pkg::REQ_APPLY;
        r.operand = $urandom;
        r.op_code = op;
        send_request(r);
    endtask

    task automatic simple_req(logic [1:0] kind);
        pse_pkg::t_in r;
        r.req_type = kind;
        r.operand = $urandom;
        r.op_code = 2'($urandom);
        send_request(r);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // Result side: sample at the edge, then stall for a random gap now and then.
    always @(posedge i_clk) begin
        if (recv_on && o_valid && !i_stall) sb.check_result(o_res);
        if (recv_on) begin
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    initial begin
        int n, k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_on = 1;
        @(posedge i_clk);

        // Directed: extremes, every operator, each error case but overflow.
        simple_req(pse_pkg::REQ_READ);                     // read on empty
        apply_op(pse_pkg::OP_ADD);                         // underflow on empty
        push_val(32'sh7fffffff); apply_op(pse_pkg::OP_SUB); // underflow with one entry
        push_val(32'sh7fffffff); push_val(32'sh7fffffff); apply_op(pse_pkg::OP_ADD);
        push_val(32'sh80000000); apply_op(pse_pkg::OP_SUB);
        push_val(32'sh80000000); apply_op(pse_pkg::OP_MUL);
        push_val(32'sh00010000); apply_op(pse_pkg::OP_DIV);
        push_val(32'sd0); apply_op(pse_pkg::OP_DIV);       // divide by zero
        push_val(-32'sd3); push_val(32'sd5); apply_op(pse_pkg::OP_MUL); // floor of negative
        push_val(32'sh80000000); push_val(-32'sd1); apply_op(pse_pkg::OP_DIV);
        simple_req(pse_pkg::REQ_READ);
        simple_req(pse_pkg::REQ_CLEAR);

        // Fill to the top and push past it.
        for (int i = 0; i < 66; i++) push_val(rand_operand());
        simple_req(pse_pkg::REQ_READ);
        simple_req(pse_pkg::REQ_CLEAR);

        // Random: mostly well-formed expressions, some noise.
        n = 0;
        while (n < 1800) begin
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(1, 6);
                push_val(rand_operand());
                for (int i = 0; i < k; i++) begin
                    push_val(rand_operand());
                    apply_op(2'($urandom));
                end
                if ($urandom_range(0, 3) == 0) simple_req(pse_pkg::REQ_READ);
                if ($urandom_range(0, 15) == 0) simple_req(pse_pkg::REQ_CLEAR);
                n += 2 * k + 1;
            end else begin
                simple_req(2'($urandom));
                n++;
            end
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
